### hdl/bpa_pkg.sv
`default_nettype none

package bpa_pkg;

   // pool geometry
   localparam int POOL_PAGES = 1024;
   localparam int TOP_ORDER  = 10;

   // word field widths
   localparam int FUNC_W = 2;
   localparam int IDX_W  = 10;
   localparam int CNT_W  = 11;
   localparam int STAT_W = 2;
   localparam int TOT_W  = 11;

   // free map storage: one bit per aligned block of every order
   localparam int MAP_BITS = 2 * POOL_PAGES;
   localparam int ROW_BITS = 32;
   localparam int BIT_W    = $clog2(ROW_BITS);
   localparam int POS_W    = $clog2(MAP_BITS);
   localparam int ROW_W    = POS_W - BIT_W;
   localparam int ROWS     = MAP_BITS / ROW_BITS;
   localparam int ORD_W    = $clog2(TOP_ORDER + 1);
   localparam int CUR_W    = $clog2(POOL_PAGES + 1);

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ALLOC = 2'd0,
      FUNC_FREE  = 2'd1,
      FUNC_ADD   = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK      = 2'd0,
      STAT_NOSPACE = 2'd1,
      STAT_RANGE   = 2'd2
   } status_type;

   typedef logic [POS_W-1:0] base_tab_type [TOP_ORDER+1];

   // first map bit of each order
   function automatic base_tab_type make_base();
      base_tab_type t;
      int acc;
      acc = 0;
      for (int o = 0; o <= TOP_ORDER; o++) begin
         t[o] = POS_W'(acc);
         acc  = acc + (POOL_PAGES >> o);
      end
      return t;
   endfunction

   localparam base_tab_type MAP_BASE = make_base();

endpackage

`default_nettype wire

### hdl/buddy_page_allocator_top.sv
`default_nettype none

// channel   | ports                                             | handshake
// ----------+---------------------------------------------------+-------------------------
// request   | req_func, req_page_index, req_page_count          | start && !busy
// response  | rsp_block_index, rsp_status, rsp_free_total       | rsp_valid, one cycle
//
// one request at a time; busy stays high until its word is shown
// every map access reads one 32-bit row, then modifies and writes it back; a scan only reads
// alloc: scans rows from the needed order upward until a free block turns up, then
//   takes the block and splits it down, handing back the right half at each order
// free: per piece, merge up with free buddies, then set its bit; add: set the piece's bit; then answer
// bad requests answer on the cycle after acceptance
// reset clears row valid bits at once, so no clearing pass; no stall from the receiver

module buddy_page_allocator_top (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [bpa_pkg::FUNC_W-1:0]  req_func,
   input  wire logic [bpa_pkg::IDX_W-1:0]   req_page_index,
   input  wire logic [bpa_pkg::CNT_W-1:0]   req_page_count,
   output logic                             rsp_valid,
   output logic [bpa_pkg::IDX_W-1:0]        rsp_block_index,
   output logic [bpa_pkg::STAT_W-1:0]       rsp_status,
   output logic [bpa_pkg::TOT_W-1:0]        rsp_free_total
);

   typedef enum logic [2:0] {S_IDLE, S_RD, S_MOD, S_PIECE, S_MERGE} state_type;
   // what the pending row access is for
   typedef enum logic [2:0] {A_SCAN, A_TAKE, A_SPLIT, A_ADD, A_BUD, A_REL} act_type;

   state_type                       state_ff;
   act_type                         act_ff;
   bpa_pkg::func_type               func_ff;
   logic [bpa_pkg::CUR_W-1:0]       idx_ff;      // next piece start
   logic [bpa_pkg::CNT_W-1:0]       n_ff;        // pages left to cut
   logic [bpa_pkg::ORD_W-1:0]       need_ff;
   logic [bpa_pkg::ORD_W-1:0]       ord_ff;      // order being scanned, split or merged
   logic [bpa_pkg::ORD_W-1:0]       pord_ff;     // order of current piece
   logic [bpa_pkg::CUR_W-1:0]       mi_ff;       // merged block start
   logic [bpa_pkg::CUR_W-1:0]       start_ff;
   logic [bpa_pkg::POS_W-1:0]       pos_ff;
   logic [bpa_pkg::ROW_W-1:0]       row_ff;
   logic [bpa_pkg::ROW_W-1:0]       last_row_ff;
   logic [bpa_pkg::TOT_W-1:0]       total_ff;
   logic                            rsp_valid_ff;
   logic [bpa_pkg::IDX_W-1:0]       blk_ff;
   logic [bpa_pkg::STAT_W-1:0]      stat_ff;

   // free map memory with per-row valid bits
   logic [bpa_pkg::ROW_BITS-1:0]    map_mem [bpa_pkg::ROWS];
   logic [bpa_pkg::ROWS-1:0]        row_valid_ff;
   logic [bpa_pkg::ROW_BITS-1:0]    rd_data_ff;

   logic                            rd_en;
   logic                            wr_en;
   logic [bpa_pkg::ROW_W-1:0]       acc_row;
   logic [bpa_pkg::ROW_BITS-1:0]    row_data;
   logic [bpa_pkg::ROW_BITS-1:0]    wr_data;
   logic [bpa_pkg::BIT_W-1:0]       bit_sel;
   logic                            old_bit;

   logic                            hit;
   logic [bpa_pkg::BIT_W-1:0]       hit_bit;
   logic [bpa_pkg::POS_W:0]         scan_lo;
   logic [bpa_pkg::POS_W:0]         scan_hi;
   logic [bpa_pkg::POS_W:0]         p_chk;

   logic [bpa_pkg::CUR_W-1:0]       bud;
   logic [bpa_pkg::CUR_W-1:0]       up;
   logic                            merge_ok;
   logic [bpa_pkg::ORD_W-1:0]       piece_ord;
   logic [bpa_pkg::CUR_W-1:0]       piece_sz;
   logic [4:0]                      need_c;
   logic [bpa_pkg::CNT_W:0]         range_end;
   logic [bpa_pkg::TOT_W:0]         tot_sum;
   logic [bpa_pkg::TOT_W-1:0]       need_sz;

   function automatic logic [bpa_pkg::CUR_W-1:0] blocks_at(input logic [4:0] o);
      return bpa_pkg::CUR_W'(bpa_pkg::POOL_PAGES >> o);
   endfunction

   function automatic logic [bpa_pkg::POS_W-1:0] pos_of(
      input logic [bpa_pkg::ORD_W-1:0] o, input logic [bpa_pkg::CUR_W-1:0] x);
      return bpa_pkg::MAP_BASE[o] + bpa_pkg::POS_W'(x >> o);
   endfunction

   function automatic logic [bpa_pkg::ROW_W-1:0] first_row(input logic [bpa_pkg::ORD_W-1:0] o);
      return bpa_pkg::MAP_BASE[o][bpa_pkg::POS_W-1:bpa_pkg::BIT_W];
   endfunction

   function automatic logic [bpa_pkg::ROW_W-1:0] last_row(input logic [bpa_pkg::ORD_W-1:0] o);
      logic [bpa_pkg::POS_W:0] e;
      e = {1'b0, bpa_pkg::MAP_BASE[o]} + (bpa_pkg::POS_W+1)'(blocks_at(5'(o)));
      if (blocks_at(5'(o)) == '0) begin
         return first_row(o);
      end
      e = e - 1'b1;
      return e[bpa_pkg::POS_W-1:bpa_pkg::BIT_W];
   endfunction

   // smallest order whose block holds n pages
   function automatic logic [4:0] ceil_order(input logic [bpa_pkg::CNT_W-1:0] n);
      logic [4:0] c;
      c = '0;
      for (int k = bpa_pkg::CNT_W; k >= 0; k--) begin
         if (((bpa_pkg::CNT_W+1)'(1) << k) >= (bpa_pkg::CNT_W+1)'(n)) c = 5'(k);
      end
      return c;
   endfunction

   // largest aligned block at s no bigger than n
   function automatic logic [bpa_pkg::ORD_W-1:0] fit_order(
      input logic [bpa_pkg::CUR_W-1:0] s, input logic [bpa_pkg::CNT_W-1:0] n);
      logic [bpa_pkg::ORD_W-1:0] f;
      logic [bpa_pkg::ORD_W-1:0] t;
      f = '0;
      for (int k = 1; k <= bpa_pkg::TOP_ORDER; k++) begin
         if ((n >> k) != '0) f = bpa_pkg::ORD_W'(k);
      end
      t = bpa_pkg::ORD_W'(bpa_pkg::TOP_ORDER);
      for (int k = bpa_pkg::TOP_ORDER - 1; k >= 0; k--) begin
         if (((s >> k) & bpa_pkg::CUR_W'(1)) != '0) t = bpa_pkg::ORD_W'(k);
      end
      return (t < f) ? t : f;
   endfunction

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_block_index = blk_ff;
   assign rsp_status     = stat_ff;
   assign rsp_free_total = total_ff;

   // shared row access unit
   always_comb begin
      rd_en    = (state_ff == S_RD);
      acc_row  = (act_ff == A_SCAN) ? row_ff : pos_ff[bpa_pkg::POS_W-1:bpa_pkg::BIT_W];
      row_data = row_valid_ff[acc_row] ? rd_data_ff : '0;
      bit_sel  = pos_ff[bpa_pkg::BIT_W-1:0];
      old_bit  = row_data[bit_sel];
      wr_en    = (state_ff == S_MOD) && (act_ff != A_SCAN);
      unique case (act_ff)
         A_TAKE, A_BUD: wr_data = row_data & ~(bpa_pkg::ROW_BITS'(1) << bit_sel);
         default:       wr_data = row_data | (bpa_pkg::ROW_BITS'(1) << bit_sel);
      endcase
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= map_mem[acc_row];
      end
      if (wr_en) begin
         map_mem[acc_row] <= wr_data;
      end
   end

   // lowest free block of the current order within the scanned row
   always_comb begin
      scan_lo = {1'b0, bpa_pkg::MAP_BASE[ord_ff]};
      scan_hi = scan_lo + (bpa_pkg::POS_W+1)'(blocks_at(5'(ord_ff)));
      hit     = 1'b0;
      hit_bit = '0;
      p_chk   = '0;
      for (int j = bpa_pkg::ROW_BITS - 1; j >= 0; j--) begin
         p_chk = {1'b0, row_ff, bpa_pkg::BIT_W'(j)};
         if (row_data[j] && p_chk >= scan_lo && p_chk < scan_hi) begin
            hit     = 1'b1;
            hit_bit = bpa_pkg::BIT_W'(j);
         end
      end
   end

   // merge step, piece cutting and request size/range checks
   always_comb begin
      bud       = mi_ff ^ (bpa_pkg::CUR_W'(1) << ord_ff);
      up        = mi_ff & ~(bpa_pkg::CUR_W'(1) << ord_ff);
      merge_ok  = (32'(ord_ff) < bpa_pkg::TOP_ORDER)
                  && ((bud >> ord_ff) < blocks_at(5'(ord_ff)))
                  && ((up >> (5'(ord_ff) + 5'd1)) < blocks_at(5'(ord_ff) + 5'd1));
      piece_ord = fit_order(idx_ff, n_ff);
      piece_sz  = bpa_pkg::CUR_W'(1) << pord_ff;
      need_c    = ceil_order(req_page_count);
      range_end = (bpa_pkg::CNT_W+1)'(req_page_index) + (bpa_pkg::CNT_W+1)'(req_page_count);
      tot_sum   = (bpa_pkg::TOT_W+1)'(total_ff) + (bpa_pkg::TOT_W+1)'(piece_sz);
      need_sz   = bpa_pkg::TOT_W'(1) << need_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         act_ff       <= A_SCAN;
         row_valid_ff <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         blk_ff       <= '0;
         stat_ff      <= bpa_pkg::STAT_OK;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (wr_en) begin
            row_valid_ff[acc_row] <= 1'b1;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  func_ff <= bpa_pkg::func_type'(req_func);
                  idx_ff  <= bpa_pkg::CUR_W'(req_page_index);
                  n_ff    <= req_page_count;
                  blk_ff  <= '0;
                  stat_ff <= bpa_pkg::STAT_OK;
                  priority if (bpa_pkg::func_type'(req_func) == bpa_pkg::FUNC_NONE) begin
                     rsp_valid_ff <= 1'b1;
                  end else if (req_page_count == '0) begin
                     stat_ff      <= bpa_pkg::STAT_NOSPACE;
                     rsp_valid_ff <= 1'b1;
                  end else if (bpa_pkg::func_type'(req_func) == bpa_pkg::FUNC_ALLOC) begin
                     if (32'(need_c) > bpa_pkg::TOP_ORDER) begin
                        stat_ff      <= bpa_pkg::STAT_NOSPACE;
                        rsp_valid_ff <= 1'b1;
                     end else begin
                        need_ff     <= bpa_pkg::ORD_W'(need_c);
                        ord_ff      <= bpa_pkg::ORD_W'(need_c);
                        row_ff      <= first_row(bpa_pkg::ORD_W'(need_c));
                        last_row_ff <= last_row(bpa_pkg::ORD_W'(need_c));
                        act_ff      <= A_SCAN;
                        state_ff    <= S_RD;
                     end
                  end else if (32'(range_end) > bpa_pkg::POOL_PAGES) begin
                     stat_ff      <= bpa_pkg::STAT_RANGE;
                     rsp_valid_ff <= 1'b1;
                  end else begin
                     state_ff <= S_PIECE;
                  end
               end
            end
            S_RD: begin
               state_ff <= S_MOD;
            end
            S_MOD: begin
               unique case (act_ff)
                  A_SCAN: begin
                     if (hit) begin
                        pos_ff   <= {row_ff, hit_bit};
                        start_ff <= bpa_pkg::CUR_W'(
                                       ({row_ff, hit_bit} - bpa_pkg::MAP_BASE[ord_ff]) << ord_ff);
                        act_ff   <= A_TAKE;
                        state_ff <= S_RD;
                     end else if (row_ff != last_row_ff) begin
                        row_ff   <= row_ff + 1'b1;
                        state_ff <= S_RD;
                     end else if (32'(ord_ff) == bpa_pkg::TOP_ORDER) begin
                        stat_ff      <= bpa_pkg::STAT_NOSPACE;
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= S_IDLE;
                     end else begin
                        ord_ff      <= ord_ff + 1'b1;
                        row_ff      <= first_row(ord_ff + 1'b1);
                        last_row_ff <= last_row(ord_ff + 1'b1);
                        state_ff    <= S_RD;
                     end
                  end
                  A_TAKE, A_SPLIT: begin
                     // hand back the right half one order down
                     if (ord_ff > need_ff) begin
                        ord_ff   <= ord_ff - 1'b1;
                        pos_ff   <= pos_of(ord_ff - 1'b1,
                                       start_ff + (bpa_pkg::CUR_W'(1) << (ord_ff - 1'b1)));
                        act_ff   <= A_SPLIT;
                        state_ff <= S_RD;
                     end else begin
                        total_ff     <= (total_ff > need_sz) ? total_ff - need_sz : '0;
                        blk_ff       <= start_ff[bpa_pkg::IDX_W-1:0];
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= S_IDLE;
                     end
                  end
                  A_BUD: begin
                     if (old_bit) begin
                        mi_ff    <= up;
                        ord_ff   <= ord_ff + 1'b1;
                        state_ff <= S_MERGE;
                     end else begin
                        pos_ff   <= pos_of(ord_ff, mi_ff);
                        act_ff   <= A_REL;
                        state_ff <= S_RD;
                     end
                  end
                  default: begin
                     // piece placed: advance the range and count it
                     idx_ff   <= idx_ff + piece_sz;
                     n_ff     <= n_ff - bpa_pkg::CNT_W'(piece_sz);
                     total_ff <= (32'(tot_sum) > bpa_pkg::POOL_PAGES)
                                 ? bpa_pkg::TOT_W'(bpa_pkg::POOL_PAGES)
                                 : tot_sum[bpa_pkg::TOT_W-1:0];
                     state_ff <= S_PIECE;
                  end
               endcase
            end
            S_PIECE: begin
               if (n_ff == '0) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else begin
                  pord_ff <= piece_ord;
                  ord_ff  <= piece_ord;
                  mi_ff   <= idx_ff;
                  if (func_ff == bpa_pkg::FUNC_ADD) begin
                     pos_ff   <= pos_of(piece_ord, idx_ff);
                     act_ff   <= A_ADD;
                     state_ff <= S_RD;
                  end else begin
                     state_ff <= S_MERGE;
                  end
               end
            end
            S_MERGE: begin
               if (merge_ok) begin
                  pos_ff <= pos_of(ord_ff, bud);
                  act_ff <= A_BUD;
               end else begin
                  pos_ff <= pos_of(ord_ff, mi_ff);
                  act_ff <= A_REL;
               end
               state_ff <= S_RD;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

### hdl/bpa_checker.sv
`default_nettype none

module bpa_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        start,
   input wire logic                        busy,
   input wire logic                        rsp_valid,
   input wire logic [bpa_pkg::IDX_W-1:0]   rsp_block_index,
   input wire logic [bpa_pkg::STAT_W-1:0]  rsp_status,
   input wire logic [bpa_pkg::TOT_W-1:0]   rsp_free_total
);

   // an accepted request is either in work or answered next cycle
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted request lost");

   // a word only ends a request
   a_word_from_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) || $past(start)))
      else $error("word without request");

   a_idle_on_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("busy while answering");

   a_fail_zero_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != bpa_pkg::STAT_OK) |-> (rsp_block_index == '0))
      else $error("failed request with block index");

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      32'(rsp_free_total) <= bpa_pkg::POOL_PAGES)
      else $error("free total above pool");

endmodule

bind buddy_page_allocator_top bpa_checker u_bpa_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_block_index (rsp_block_index),
   .rsp_status      (rsp_status),
   .rsp_free_total  (rsp_free_total)
);

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps

module tb;

   logic                         clock;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic [bpa_pkg::FUNC_W-1:0]   req_func;
   logic [bpa_pkg::IDX_W-1:0]    req_page_index;
   logic [bpa_pkg::CNT_W-1:0]    req_page_count;
   logic                         rsp_valid;
   logic [bpa_pkg::IDX_W-1:0]    rsp_block_index;
   logic [bpa_pkg::STAT_W-1:0]   rsp_status;
   logic [bpa_pkg::TOT_W-1:0]    rsp_free_total;

   buddy_page_allocator_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_page_index(req_page_index),
      .req_page_count(req_page_count), .rsp_valid(rsp_valid),
      .rsp_block_index(rsp_block_index), .rsp_status(rsp_status),
      .rsp_free_total(rsp_free_total)
   );

   // one expected response word
   typedef struct packed {
      logic [bpa_pkg::IDX_W-1:0]  blk;
      logic [bpa_pkg::STAT_W-1:0] stat;
      logic [bpa_pkg::TOT_W-1:0]  total;
   } answer_type;

   // directed row: typed answer only where it is obvious
   typedef struct {
      bpa_pkg::func_type fn;
      int                idx;
      int                cnt;
      bit                typed;
      answer_type        ans;
   } row_type;

   // shadow allocator state
   bit  free_map [bpa_pkg::TOP_ORDER+1][bpa_pkg::POOL_PAGES];
   int  pages_free;

   answer_type pending_answers [$];
   int  bad_words;
   int  idle_cycles;
   bit  timed_out;

   function automatic int blocks_in(int o);
      return bpa_pkg::POOL_PAGES >> o;
   endfunction

   function automatic bit map_rd(int o, int b);
      if (b >= blocks_in(o)) return 0;
      return free_map[o][b];
   endfunction

   function automatic void map_wr(int o, int b, bit v);
      if (b < blocks_in(o)) free_map[o][b] = v;
   endfunction

   function automatic void grow_total(int n);
      pages_free = (pages_free + n > bpa_pkg::POOL_PAGES) ? bpa_pkg::POOL_PAGES
                                                          : pages_free + n;
   endfunction

   function automatic int largest_fit(int s, int n);
      int o;
      o = 0;
      while (o < bpa_pkg::TOP_ORDER && (2 << o) <= n) o++;
      while (o > 0 && (s & ((1 << o) - 1)) != 0) o--;
      return o;
   endfunction

   // merge a freed piece upward with its free buddy
   function automatic void merge_up(int s, int o);
      int bud, up;
      while (o < bpa_pkg::TOP_ORDER) begin
         bud = s ^ (1 << o);
         up  = s & ~(1 << o);
         if (!map_rd(o, bud >> o)) break;
         if ((up >> (o + 1)) >= blocks_in(o + 1)) break;
         map_wr(o, bud >> o, 0);
         s = up;
         o++;
      end
      map_wr(o, s >> o, 1);
   endfunction

   function automatic answer_type predict_word(logic [1:0] fn, int idx, int cnt);
      answer_type a;
      int need, o, b, sz, s;
      bit found;
      a = '0;
      if (fn == bpa_pkg::FUNC_ALLOC) begin
         need = 0;
         while ((1 << need) < cnt && need < 31) need++;
         if (cnt == 0 || need > bpa_pkg::TOP_ORDER) a.stat = bpa_pkg::STAT_NOSPACE;
         else begin
            found = 0;
            for (o = need; o <= bpa_pkg::TOP_ORDER && !found; o++) begin
               for (b = 0; b < blocks_in(o); b++)
                  if (map_rd(o, b)) begin
                     found = 1;
                     break;
                  end
               if (found) break;
            end
            if (!found) a.stat = bpa_pkg::STAT_NOSPACE;
            else begin
               s = b << o;
               map_wr(o, b, 0);
               while (o > need) begin
                  o--;
                  map_wr(o, (s + (1 << o)) >> o, 1);
               end
               pages_free = (pages_free > (1 << need)) ? pages_free - (1 << need) : 0;
               a.blk = bpa_pkg::IDX_W'(s);
            end
         end
      end else if (fn == bpa_pkg::FUNC_FREE || fn == bpa_pkg::FUNC_ADD) begin
         if (cnt == 0) a.stat = bpa_pkg::STAT_NOSPACE;
         else if (idx + cnt > bpa_pkg::POOL_PAGES) a.stat = bpa_pkg::STAT_RANGE;
         else begin
            s = idx;
            while (cnt != 0) begin
               o  = largest_fit(s, cnt);
               sz = 1 << o;
               if (fn == bpa_pkg::FUNC_FREE) merge_up(s, o);
               else map_wr(o, s >> o, 1);
               s   += sz;
               cnt -= sz;
               grow_total(sz);
            end
         end
      end
      a.total = bpa_pkg::TOT_W'(pages_free);
      return a;
   endfunction

   // clock
   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // response checker, sampled at the rising edge
   always @(posedge clock) begin
      answer_type got, want;
      if (!reset && rsp_valid) begin
         got = {rsp_block_index, rsp_status, rsp_free_total};
         if (pending_answers.size() == 0) begin
            bad_words++;
            if (bad_words <= 10)
               $display("unexpected word: blk %0d stat %0d total %0d",
                        got.blk, got.stat, got.total);
         end else begin
            want = pending_answers.pop_front();
            if (got !== want) begin
               bad_words++;
               if (bad_words <= 10)
                  $display("wrong word: exp blk %0d stat %0d total %0d, got blk %0d stat %0d total %0d",
                           want.blk, want.stat, want.total, got.blk, got.stat, got.total);
            end
         end
      end
   end

   // watchdog: cycles with nothing accepted or answered
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("buddy_page_allocator_top: mismatch");
         $finish;
      end
   end

   // drive one word at a falling edge and return at its accepting edge
   task automatic send_word(logic [1:0] fn, int idx, int cnt, bit typed, answer_type ans,
                            bit may_idle);
      answer_type p;
      @(negedge clock);
      while (may_idle && $urandom_range(99) < 17) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start          <= 1'b1;
      req_func       <= fn;
      req_page_index <= idx[bpa_pkg::IDX_W-1:0];
      req_page_count <= cnt[bpa_pkg::CNT_W-1:0];
      // busy only moves at rising edges, so it is stable here
      while (busy) @(negedge clock);
      @(posedge clock);
      p = predict_word(fn, idx, cnt);
      // typed rows double-check the shadow model too
      if (typed && p !== ans) begin
         bad_words++;
         if (bad_words <= 10)
            $display("table row disagrees: fn %0d idx %0d cnt %0d, exp blk %0d stat %0d total %0d, model blk %0d stat %0d total %0d",
                     fn, idx, cnt, ans.blk, ans.stat, ans.total, p.blk, p.stat, p.total);
      end
      pending_answers.push_back(typed ? ans : p);
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending_answers.size() != 0) @(negedge clock);
   endtask

   row_type dir_rows [$];
   row_type r;

   function automatic row_type mk(bpa_pkg::func_type fn, int idx, int cnt, bit typed,
                                  int blk, bpa_pkg::status_type st, int tot);
      row_type x;
      x.fn = fn; x.idx = idx; x.cnt = cnt; x.typed = typed;
      x.ans.blk = bpa_pkg::IDX_W'(blk); x.ans.stat = st; x.ans.total = bpa_pkg::TOT_W'(tot);
      return x;
   endfunction

   initial begin
      int n, kind, idx, cnt, mode;
      logic [1:0] fn;
      bad_words = 0;
      start = 0; req_func = '0; req_page_index = '0; req_page_count = '0;
      reset = 1;
      pages_free = 0;
      foreach (free_map[o, b]) free_map[o][b] = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed table
      dir_rows.push_back(mk(bpa_pkg::FUNC_ALLOC, 0, 1, 1, 0, bpa_pkg::STAT_NOSPACE, 0)); // empty pool
      dir_rows.push_back(mk(bpa_pkg::FUNC_ALLOC, 0, 0, 1, 0, bpa_pkg::STAT_NOSPACE, 0)); // zero count
      dir_rows.push_back(mk(bpa_pkg::FUNC_ADD, 5, 0, 1, 0, bpa_pkg::STAT_NOSPACE, 0));
      dir_rows.push_back(mk(bpa_pkg::FUNC_ADD, 1023, 2, 1, 0, bpa_pkg::STAT_RANGE, 0));  // outside pool
      dir_rows.push_back(mk(bpa_pkg::FUNC_FREE, 1, 1024, 1, 0, bpa_pkg::STAT_RANGE, 0));
      dir_rows.push_back(mk(bpa_pkg::FUNC_NONE, 1023, 2047, 1, 0, bpa_pkg::STAT_OK, 0)); // unused code
      dir_rows.push_back(mk(bpa_pkg::FUNC_ADD, 0, 1024, 1, 0, bpa_pkg::STAT_OK, 1024));  // whole pool
      dir_rows.push_back(mk(bpa_pkg::FUNC_ADD, 3, 7, 1, 0, bpa_pkg::STAT_OK, 1024));     // saturates
      dir_rows.push_back(mk(bpa_pkg::FUNC_ALLOC, 0, 1025, 1, 0,
                            bpa_pkg::STAT_NOSPACE, 1024));                               // too large
      dir_rows.push_back(mk(bpa_pkg::FUNC_ALLOC, 1023, 1024, 0, 0, bpa_pkg::STAT_OK, 0));
      dir_rows.push_back(mk(bpa_pkg::FUNC_ALLOC, 0, 1, 0, 0, bpa_pkg::STAT_OK, 0));
      dir_rows.push_back(mk(bpa_pkg::FUNC_ALLOC, 0, 3, 0, 0, bpa_pkg::STAT_OK, 0));
      dir_rows.push_back(mk(bpa_pkg::FUNC_FREE, 0, 1024, 0, 0, bpa_pkg::STAT_OK, 0));
      dir_rows.push_back(mk(bpa_pkg::FUNC_ALLOC, 0, 1024, 0, 0, bpa_pkg::STAT_OK, 0));
      dir_rows.push_back(mk(bpa_pkg::FUNC_ALLOC, 0, 1, 0, 0, bpa_pkg::STAT_OK, 0));
      dir_rows.push_back(mk(bpa_pkg::FUNC_FREE, 1023, 1, 0, 0, bpa_pkg::STAT_OK, 0));   // top page
      dir_rows.push_back(mk(bpa_pkg::FUNC_FREE, 512, 511, 0, 0, bpa_pkg::STAT_OK, 0));  // merges up
      dir_rows.push_back(mk(bpa_pkg::FUNC_FREE, 0, 512, 0, 0, bpa_pkg::STAT_OK, 0));
      dir_rows.push_back(mk(bpa_pkg::FUNC_ALLOC, 0, 513, 0, 0, bpa_pkg::STAT_OK, 0));
      dir_rows.push_back(mk(bpa_pkg::FUNC_FREE, 0, 1024, 0, 0, bpa_pkg::STAT_OK, 0));   // double free
      dir_rows.push_back(mk(bpa_pkg::FUNC_ALLOC, 682, 1000, 0, 0, bpa_pkg::STAT_OK, 0));
      foreach (dir_rows[i]) begin
         r = dir_rows[i];
         send_word(r.fn, r.idx, r.cnt, r.typed, r.ans, 0);
      end
      // sender holds off until the block has answered everything
      drain();

      // random part: mostly alloc/free churn over a fragmented pool
      for (n = 0; n < 1200; n++) begin
         mode = (n >= 300 && n < 500) ? 0 : 1;   // stretch without idling
         kind = $urandom_range(99);
         if (kind < 40) begin
            fn = bpa_pkg::FUNC_ALLOC;
            idx = $urandom_range(1023);
            cnt = ($urandom_range(9) == 0) ? $urandom_range(2047)
                                           : (1 << $urandom_range(6)) - $urandom_range(1);
         end else if (kind < 85) begin
            fn = (kind < 75) ? bpa_pkg::FUNC_FREE : bpa_pkg::FUNC_ADD;
            cnt = ($urandom_range(9) == 0) ? $urandom_range(1024) : $urandom_range(1, 40);
            idx = ($urandom_range(7) == 0) ? $urandom_range(1023)
                                           : $urandom_range(0, bpa_pkg::POOL_PAGES - cnt);
         end else begin
            fn = 2'($urandom_range(3));
            idx = $urandom_range(1023);
            cnt = $urandom_range(2047);
         end
         send_word(fn, idx, cnt, 0, '0, mode[0]);
         if (n == 600) drain();
      end

      drain();
      repeat (100) @(posedge clock);
      if (bad_words == 0) $display("buddy_page_allocator_top: match");
      else $display("buddy_page_allocator_top: mismatch");
      $finish;
   end

endmodule

### sim.f
hdl/bpa_pkg.sv
hdl/buddy_page_allocator_top.sv
hdl/bpa_checker.sv
tb/tb.sv
